### sv/llpr_pkg.sv
`timescale 1ns / 1ps

package llpr_pkg;

   localparam int unsigned IDX_W     = 8;
   localparam int unsigned LEVEL_W   = 6;
   localparam int unsigned CH_W      = 8;
   localparam int unsigned FB_W      = 9;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned SQ_W      = 2 * CH_W;
   localparam int unsigned DIST_W    = SQ_W + 2;
   localparam int unsigned PROD_W    = CH_W + LEVEL_W;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 8;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 6'd63;
   localparam logic [PROD_W:0]    DIM_ROUND  = 15'd16;
   localparam int unsigned        DIM_SHIFT  = 5;
   localparam logic [CH_W-1:0]    CH_MAX     = 8'd255;
   localparam logic [FB_W-1:0]    FB_RESET   = 9'd32;

   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MATCH  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   typedef struct packed {
      logic load_req;
      logic wr_en;
      logic rd_src;
      logic load_dim;
      logic scan_step;
      logic set_direct;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic fullbright;
      logic scan_last;
      logic pipe_busy;
   } sts_type;

endpackage

### sv/llpr_ram.sv
`timescale 1ns / 1ps

module llpr_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/llpr_dp.sv
`timescale 1ns / 1ps

module llpr_dp #(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [llpr_pkg::IDX_W-1:0]       entry_index,
   input  logic [llpr_pkg::LEVEL_W-1:0]     light_level,
   input  logic [llpr_pkg::CH_W-1:0]        red,
   input  logic [llpr_pkg::CH_W-1:0]        green,
   input  logic [llpr_pkg::CH_W-1:0]        blue,
   input  logic                             csr_we,
   input  logic [llpr_pkg::FB_W-1:0]        csr_wdata,
   input  llpr_pkg::cmd_type                cmd,
   output llpr_pkg::sts_type                sts,
   output logic [llpr_pkg::IDX_W-1:0]       match_index
);

   import llpr_pkg::*;

   localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
   localparam logic [FB_W:0] ENTRIES_CMP = (FB_W + 1)'(PALETTE_ENTRIES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

   logic [FB_W-1:0]    fullbright_ff, fullbright_in;
   logic [IDX_W-1:0]   src_idx_ff, src_idx_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [CH_W-1:0]    tgt_r_ff, tgt_r_in;
   logic [CH_W-1:0]    tgt_g_ff, tgt_g_in;
   logic [CH_W-1:0]    tgt_b_ff, tgt_b_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic               v1_ff, v1_in;
   logic               v2_ff, v2_in;
   logic               v3_ff, v3_in;
   logic [AW-1:0]      tag1_ff, tag1_in;
   logic [AW-1:0]      tag2_ff, tag2_in;
   logic [AW-1:0]      tag3_ff, tag3_in;
   logic [SQ_W-1:0]    sq_r_ff, sq_r_in;
   logic [SQ_W-1:0]    sq_g_ff, sq_g_in;
   logic [SQ_W-1:0]    sq_b_ff, sq_b_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [DIST_W-1:0]  min_dist_ff, min_dist_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;

   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [3*CH_W-1:0]  ram_rd_data;
   logic [CH_W-1:0]    pal_r, pal_g, pal_b;
   logic [CH_W-1:0]    dim_r, dim_g, dim_b;
   logic [CH_W-1:0]    diff_r, diff_g, diff_b;

   function automatic logic [CH_W-1:0] dim_channel(input logic [CH_W-1:0] v,
                                                   input logic [LEVEL_W-1:0] lvl);
      logic [PROD_W-1:0] prod;
      logic [PROD_W:0]   sum;
      logic [PROD_W-DIM_SHIFT:0] x;
      prod = PROD_W'(v) * PROD_W'(LEVEL_FULL - lvl);
      sum  = {1'b0, prod} + DIM_ROUND;
      x    = sum[PROD_W:DIM_SHIFT];
      if (x > (PROD_W - DIM_SHIFT + 1)'(CH_MAX)) begin
         return CH_MAX;
      end
      return x[CH_W-1:0];
   endfunction

   function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   llpr_ram #(
      .WIDTH(3 * CH_W),
      .DEPTH(PALETTE_ENTRIES)
   ) u_palette (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(entry_index[AW-1:0]),
      .wr_data({blue, green, red}),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign ram_rd_en   = cmd.rd_src | cmd.scan_step;
   assign ram_rd_addr = cmd.rd_src ? src_idx_ff[AW-1:0] : cnt_ff;
   assign pal_r = ram_rd_data[CH_W-1:0];
   assign pal_g = ram_rd_data[2*CH_W-1:CH_W];
   assign pal_b = ram_rd_data[3*CH_W-1:2*CH_W];

   assign dim_r = dim_channel(pal_r, level_ff);
   assign dim_g = dim_channel(pal_g, level_ff);
   assign dim_b = dim_channel(pal_b, level_ff);

   assign diff_r = abs_diff(pal_r, tgt_r_ff);
   assign diff_g = abs_diff(pal_g, tgt_g_ff);
   assign diff_b = abs_diff(pal_b, tgt_b_ff);

   always_comb begin
      fullbright_in = csr_we ? csr_wdata : fullbright_ff;

      src_idx_in = cmd.load_req ? entry_index : src_idx_ff;
      level_in   = cmd.load_req ? light_level : level_ff;
      tgt_r_in   = tgt_r_ff;
      tgt_g_in   = tgt_g_ff;
      tgt_b_in   = tgt_b_ff;
      if (cmd.load_req) begin
         tgt_r_in = red;
         tgt_g_in = green;
         tgt_b_in = blue;
      end else if (cmd.load_dim) begin
         tgt_r_in = dim_r;
         tgt_g_in = dim_g;
         tgt_b_in = dim_b;
      end

      cnt_in = cnt_ff;
      if (cmd.load_req) begin
         cnt_in = '0;
      end else if (cmd.scan_step) begin
         cnt_in = cnt_ff + AW'(1);
      end

      v1_in   = cmd.scan_step;
      tag1_in = cnt_ff;
      v2_in   = v1_ff;
      tag2_in = tag1_ff;
      sq_r_in = SQ_W'(diff_r) * SQ_W'(diff_r);
      sq_g_in = SQ_W'(diff_g) * SQ_W'(diff_g);
      sq_b_in = SQ_W'(diff_b) * SQ_W'(diff_b);
      v3_in   = v2_ff;
      tag3_in = tag2_ff;
      dist_in = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

      min_dist_in = min_dist_ff;
      best_idx_in = best_idx_ff;
      if (cmd.set_direct) begin
         best_idx_in = entry_index;
      end else if (v3_ff && (tag3_ff == '0 || dist_ff < min_dist_ff)) begin
         min_dist_in = dist_ff;
         best_idx_in = IDX_W'(tag3_ff);
      end

      rsp_idx_in = cmd.out_load ? best_idx_ff : rsp_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fullbright_ff <= FB_RESET;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
      end else begin
         fullbright_ff <= fullbright_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         v3_ff         <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      src_idx_ff   <= src_idx_in;
      level_ff     <= level_in;
      tgt_r_ff     <= tgt_r_in;
      tgt_g_ff     <= tgt_g_in;
      tgt_b_ff     <= tgt_b_in;
      cnt_ff       <= cnt_in;
      tag1_ff      <= tag1_in;
      tag2_ff      <= tag2_in;
      tag3_ff      <= tag3_in;
      sq_r_ff      <= sq_r_in;
      sq_g_ff      <= sq_g_in;
      sq_b_ff      <= sq_b_in;
      dist_ff      <= dist_in;
      min_dist_ff  <= min_dist_in;
      best_idx_ff  <= best_idx_in;
      rsp_idx_ff   <= rsp_idx_in;
   end

   assign sts.in_range   = {1'b0, 1'b0, entry_index} < ENTRIES_CMP;
   assign sts.fullbright = ({2'b00, entry_index} + {1'b0, fullbright_ff}) >= ENTRIES_CMP;
   assign sts.scan_last  = (cnt_ff == LAST_ADDR);
   assign sts.pipe_busy  = v1_ff | v2_ff | v3_ff;
   assign match_index    = rsp_idx_ff;

`ifndef ASSERT_OFF
   a_load_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> !v1_ff && !v2_ff && !v3_ff)
      else $error("A new word was loaded while the distance pipeline was busy.");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !cmd.scan_step && !cmd.rd_src && !sts.pipe_busy)
      else $error("A palette write collided with a palette read.");

   a_v3_follows_v2: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> $past(v2_ff))
      else $error("The compare stage saw a distance that was never summed.");
`endif

endmodule

### sv/llpr_ctrl.sv
`timescale 1ns / 1ps

module llpr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [llpr_pkg::KIND_W-1:0]   req_kind,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  llpr_pkg::sts_type             sts,
   output llpr_pkg::cmd_type             cmd
);

   import llpr_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FETCH  = 6'b000010,
      ST_DIM    = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               unique case (req_kind)
                  KIND_WRITE: begin
                     cmd.wr_en = sts.in_range;
                  end
                  KIND_LOOKUP: begin
                     if (sts.fullbright) begin
                        cmd.set_direct = 1'b1;
                        state_in       = ST_FINISH;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  KIND_MATCH: begin
                     state_in = ST_SCAN;
                  end
                  KIND_NONE: begin
                     state_in = ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            cmd.rd_src = 1'b1;
            state_in   = ST_DIM;
         end
         ST_DIM: begin
            cmd.load_dim = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !cmd.out_load)
      else $error("A pending result word was overwritten.");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && out_free |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("A finished search did not present its result.");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      sts.pipe_busy |-> state_ff == ST_SCAN || state_ff == ST_DRAIN)
      else $error("The distance pipeline ran outside a scan.");
`endif

endmodule

### sv/light_level_palette_remap_top.sv
`timescale 1ns / 1ps
// A fullbright lookup goes straight to ST_FINISH; a raw match first scans the palette and drains
// the distance pipeline, and a dimmed lookup also fetches and dims its source entry before the scan.
// Requests are taken only in ST_IDLE, so a search ends before the next word is accepted; the scan
// walks the single read port of the palette RAM one entry per cycle; writes go one per cycle.
// Reset is synchronous and active high: it clears the controller, the output valid and the
// pipeline valid bits, and sets fullbright_count to 32; palette contents are left undefined.

module light_level_palette_remap_top #(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // entry_index[7:0], light_level[13:8], red[21:14], green[29:22], blue[37:30], zero pad
   input  logic [39:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // match_index[7:0]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata
);

   import llpr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   llpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_kind  (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   llpr_dp #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .entry_index(req_tdata[7:0]),
      .light_level(req_tdata[13:8]),
      .red        (req_tdata[21:14]),
      .green      (req_tdata[29:22]),
      .blue       (req_tdata[37:30]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .match_index(rsp_tdata)
   );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import llpr_pkg::*;

   localparam int ENTRIES        = 256;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_OFF       = 1500;
   localparam int DRAIN_CYCLES   = 300;
   localparam int PHASE_ITEMS    = 145;

   typedef struct packed {
      logic [1:0] pad;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [5:0] level;
      logic [7:0] idx;
   } req_word_t;

   class palette_scoreboard;
      logic [23:0] pal [ENTRIES];
      logic [8:0]  fb_count;
      logic [7:0]  match_q [$];
      int          errors;

      function new();
         fb_count = FB_RESET;
         errors   = 0;
         foreach (pal[i]) pal[i] = '0;
      endfunction

      function void set_fullbright(logic [8:0] v);
         fb_count = v;
      endfunction

      function logic [7:0] dim(logic [7:0] v, logic [5:0] lvl);
         int x;
         x = (int'(v) * (int'(LEVEL_FULL) - int'(lvl)) + int'(DIM_ROUND)) >> DIM_SHIFT;
         if (x > int'(CH_MAX)) x = int'(CH_MAX);
         return x[7:0];
      endfunction

      function logic [7:0] nearest(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         int best;
         int min_err;
         int dr;
         int dg;
         int db;
         int err_sum;
         best = 0;
         min_err = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            dr = int'(r) - int'(pal[i][23:16]);
            dg = int'(g) - int'(pal[i][15:8]);
            db = int'(b) - int'(pal[i][7:0]);
            err_sum = dr * dr + dg * dg + db * db;
            if (i == 0 || err_sum < min_err) begin
               best = i;
               min_err = err_sum;
            end
         end
         return best[7:0];
      endfunction

      function void note_input(logic [1:0] kind, req_word_t w);
         logic [23:0] c;
         case (kind)
            KIND_WRITE: begin
               pal[w.idx] = {w.red, w.green, w.blue};
            end
            KIND_LOOKUP: begin
               if (int'(w.idx) + int'(fb_count) >= ENTRIES) begin
                  match_q.push_back(w.idx);
               end else begin
                  c = pal[w.idx];
                  match_q.push_back(nearest(dim(c[23:16], w.level), dim(c[15:8], w.level),
                                            dim(c[7:0], w.level)));
               end
            end
            KIND_MATCH: begin
               match_q.push_back(nearest(w.red, w.green, w.blue));
            end
            default: begin
            end
         endcase
      endfunction

      function void check_result(logic [7:0] got);
         logic [7:0] want;
         if (match_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result word: match_index %0d", got);
         end else begin
            want = match_q.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) begin
                  $display("Mismatch: match_index expected %0d, got %0d", want, got);
               end
            end
         end
      endfunction

      function int pending();
         return match_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = KIND_NONE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [8:0]  csr_wdata  = '0;

   palette_scoreboard sb;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_cycles   = 0;
   int quiet_cycles  = 0;

   light_level_palette_remap_top #(
      .PALETTE_ENTRIES(ENTRIES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.set_fullbright(csr_wdata);
         if (req_tvalid && req_tready) sb.note_input(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic req_word_t make_word(logic [7:0] idx, logic [5:0] lvl, logic [7:0] r,
                                           logic [7:0] g, logic [7:0] b);
      req_word_t w;
      w.pad   = '0;
      w.idx   = idx;
      w.level = lvl;
      w.red   = r;
      w.green = g;
      w.blue  = b;
      return w;
   endfunction

   task automatic send_word(input logic [1:0] kind, input req_word_t w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [8:0] fb, input int send_pct, input int stall_pct,
                            input bit pressure);
      req_word_t   w;
      logic [1:0]  kind;
      logic [23:0] c;
      int          sel;
      int          t;
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= fb;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      if (pressure) begin
         @(posedge clock);
         hold_cycles = HOLD_OFF;
         @(negedge clock);
      end
      repeat (PHASE_ITEMS) begin
         sel = $urandom_range(99);
         w = make_word(8'($urandom_range(255)), 6'($urandom_range(63)),
                       8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
         c = sb.pal[$urandom_range(ENTRIES - 1)];
         if (sel < 30) begin
            kind = KIND_WRITE;
            if ($urandom_range(3) == 0) {w.red, w.green, w.blue} = c;
         end else if (sel < 65) begin
            kind = KIND_LOOKUP;
            case ($urandom_range(7))
               0: w.level = '0;
               1: w.level = LEVEL_FULL;
               default: begin
               end
            endcase
            if ($urandom_range(3) == 0) begin
               t = ENTRIES - int'(sb.fb_count) + int'($urandom_range(2)) - 1;
               if (t < 0) t = 0;
               if (t > ENTRIES - 1) t = ENTRIES - 1;
               w.idx = t[7:0];
            end
         end else if (sel < 95) begin
            kind = KIND_MATCH;
            case ($urandom_range(3))
               0: {w.red, w.green, w.blue} = c;
               1: begin
                  w.red   = 8'(c[23:16] + $urandom_range(2) - 1);
                  w.green = 8'(c[15:8] + $urandom_range(2) - 1);
                  w.blue  = 8'(c[7:0] + $urandom_range(2) - 1);
               end
               default: begin
               end
            endcase
         end else begin
            kind = KIND_NONE;
         end
         send_word(kind, w);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [23:0] c;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Load every palette entry first, with black and white at the ends and some repeats.
      for (int i = 0; i < ENTRIES; i++) begin
         if (i == 0) begin
            c = 24'h000000;
         end else if (i == ENTRIES - 1) begin
            c = 24'hFFFFFF;
         end else if (i > 1 && $urandom_range(7) == 0) begin
            c = sb.pal[$urandom_range(i - 1)];
         end else begin
            c = {8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255))};
         end
         send_word(KIND_WRITE, make_word(8'(i), 6'($urandom_range(63)), c[23:16], c[15:8],
                                         c[7:0]));
      end

      // Directed words under the reset fullbright count.
      send_word(KIND_LOOKUP, make_word(8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
      send_word(KIND_LOOKUP, make_word(8'd223, 6'd63, 8'd255, 8'd255, 8'd255));
      send_word(KIND_LOOKUP, make_word(8'd224, 6'd20, 8'd0, 8'd0, 8'd0));
      send_word(KIND_LOOKUP, make_word(8'd255, 6'd0, 8'd0, 8'd0, 8'd0));
      send_word(KIND_LOOKUP, make_word(8'd100, 6'd0, 8'd0, 8'd0, 8'd0));
      send_word(KIND_LOOKUP, make_word(8'd100, 6'd31, 8'd0, 8'd0, 8'd0));
      send_word(KIND_LOOKUP, make_word(8'd100, 6'd62, 8'd0, 8'd0, 8'd0));
      send_word(KIND_MATCH, make_word(8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
      send_word(KIND_MATCH, make_word(8'd255, 6'd63, 8'd255, 8'd255, 8'd255));
      send_word(KIND_MATCH, make_word(8'd0, 6'd0, 8'd255, 8'd0, 8'd0));
      send_word(KIND_MATCH, make_word(8'd0, 6'd0, 8'd0, 8'd255, 8'd0));
      send_word(KIND_MATCH, make_word(8'd0, 6'd0, 8'd0, 8'd0, 8'd255));
      send_word(KIND_MATCH, make_word(8'd0, 6'd0, 8'd128, 8'd128, 8'd128));
      send_word(KIND_NONE, make_word(8'd255, 6'd63, 8'd255, 8'd255, 8'd255));
      send_word(KIND_NONE, make_word(8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
      send_word(KIND_WRITE, make_word(8'd17, 6'd0, 8'd255, 8'd255, 8'd255));
      send_word(KIND_LOOKUP, make_word(8'd17, 6'd0, 8'd0, 8'd0, 8'd0));
      send_word(KIND_LOOKUP, make_word(8'd17, 6'd1, 8'd0, 8'd0, 8'd0));
      c = sb.pal[10];
      send_word(KIND_WRITE, make_word(8'd200, 6'd0, c[23:16], c[15:8], c[7:0]));
      send_word(KIND_MATCH, make_word(8'd0, 6'd0, c[23:16], c[15:8], c[7:0]));
      send_word(KIND_WRITE, make_word(8'd0, 6'd0, 8'd255, 8'd255, 8'd255));
      send_word(KIND_WRITE, make_word(8'd255, 6'd0, 8'd0, 8'd0, 8'd0));
      send_word(KIND_MATCH, make_word(8'd0, 6'd0, 8'd255, 8'd255, 8'd255));
      send_word(KIND_MATCH, make_word(8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
      req_tvalid <= 1'b0;

      run_phase(9'd0, 0, 0, 1'b0);
      run_phase(9'd256, 48, 0, 1'b0);
      run_phase(9'd255, 0, 48, 1'b0);
      run_phase(9'($urandom_range(ENTRIES)), 10, 10, 1'b1);
      run_phase(9'd1, 0, 0, 1'b0);
      run_phase(9'($urandom_range(ENTRIES - 2, 2)), 10, 10, 1'b0);

      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
sv/llpr_pkg.sv
sv/llpr_ram.sv
sv/llpr_dp.sv
sv/llpr_ctrl.sv
sv/light_level_palette_remap_top.sv
verif/tb_top.sv
